>>> hdl/brst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring package
// Sizes, operation codes and beat types shared by the broadcast ring files.
// ----------------------------------------------------------------------------
package brst_pkg;

   localparam int DEPTH       = 1024;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int PAY_W       = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_CREATE   = 2'd0,
      OP_GET      = 2'd1,
      OP_GET_NEXT = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] req_id;
      logic [31:0] in_data;
   } req_payload_type;

   typedef struct packed {
      logic        res_found;
      logic [31:0] res_id;
      logic [31:0] res_data;
   } rsp_payload_type;

   typedef struct packed {
      op_type           op;
      logic [31:0]      id;
      logic [PAY_W-1:0] data;
      logic [IDX_W-1:0] slot;
   } work_item_type;

endpackage
`default_nettype wire

>>> hdl/brst_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring channels
// Valid/ready channel interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface brst_req_if;
   import brst_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface brst_rsp_if;
   import brst_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hdl/broadcast_ring_with_sequence_tags_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring with sequence tags
// Ring of tagged payload words shared by independent readers.
// ----------------------------------------------------------------------------
// After reset the block sweeps its tag memory to zero, one slot a cycle,
// through all DEPTH (1024) slots, and holds req_bus.ready low until that is done.
// Requests pass a front register and a two-entry queue, then the back end
// executes them one at a time: create and clear finish in the run state,
// get also passes ST_LOOK1 and get-next ST_LOOK1 and ST_LOOK2, set by the
// single registered read port of the tag and payload memories (get-next
// reads its own slot, then the following or the oldest slot). Every request
// gives exactly one response beat from an output register, so a waiting
// response does not stop new requests from entering the queue until it fills.
module broadcast_ring_with_sequence_tags_unit (
   input  logic       clock,
   input  logic       reset,
   brst_req_if.sink   req_bus,
   brst_rsp_if.source rsp_bus
);
   import brst_pkg::*;

   logic          front_valid, front_ready;
   work_item_type front_item;
   logic          head_valid, head_pop;
   work_item_type head_item;
   logic          init_done;

   brst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .enable     (init_done),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   brst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .in_ready  (front_ready),
      .out_valid (head_valid),
      .out_item  (head_item),
      .out_ready (head_pop)
   );

   brst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_item),
      .head_pop   (head_pop),
      .rsp_bus    (rsp_bus),
      .init_done  (init_done)
   );

endmodule
`default_nettype wire

>>> hdl/brst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hdl/brst_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring front end
// Accepts request beats, decodes the operation and the ring slot, and holds
// the decoded item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module brst_front (
   input  logic                   clock,
   input  logic                   reset,
   brst_req_if.sink               req_bus,
   input  logic                   enable,
   output logic                   item_valid,
   output brst_pkg::work_item_type item,
   input  logic                   item_ready
);
   import brst_pkg::*;

   logic          valid_ff, valid_in;
   work_item_type item_ff, item_in;
   logic          accept;

   assign req_bus.ready = enable && (!valid_ff || item_ready);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in     = 1'b1;
         item_in.op   = op_type'(req_bus.payload.operation);
         item_in.id   = req_bus.payload.req_id;
         item_in.data = req_bus.payload.in_data[PAY_W-1:0];
         item_in.slot = req_bus.payload.req_id[IDX_W-1:0];
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

>>> hdl/brst_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module brst_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  brst_pkg::work_item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output brst_pkg::work_item_type out_item,
   input  logic                    out_ready
);
   import brst_pkg::*;

   work_item_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

>>> hdl/brst_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring back end
// Owns the tag and payload memories and the ring counters, executes one
// item at a time and drives the registered response channel.
// ----------------------------------------------------------------------------
module brst_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  brst_pkg::work_item_type head,
   output logic                    head_pop,
   brst_rsp_if.source              rsp_bus,
   output logic                    init_done
);
   import brst_pkg::*;

   typedef enum logic [1:0] {
      ST_INIT,
      ST_RUN,
      ST_LOOK1,
      ST_LOOK2
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] init_cnt_ff, init_cnt_in;
   logic [31:0]      next_ff, next_in;
   logic [IDX_W-1:0] wslot_ff, wslot_in;
   logic [31:0]      bound_ff, bound_in;
   logic [31:0]      req_ff, req_in;
   op_type           op_ff, op_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             tag_we, pay_we, mem_re;
   logic [IDX_W-1:0] waddr, raddr;
   logic [31:0]      tag_wdata, tag_rd;
   logic [PAY_W-1:0] pay_rd;
   logic             out_free, live, hit, ok;
   logic [31:0]      rounded;

   brst_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_tag_ram (
      .clock (clock),
      .we    (tag_we),
      .waddr (waddr),
      .wdata (tag_wdata),
      .re    (mem_re),
      .raddr (raddr),
      .rdata (tag_rd)
   );

   brst_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
      .clock (clock),
      .we    (pay_we),
      .waddr (waddr),
      .wdata (head.data),
      .re    (mem_re),
      .raddr (raddr),
      .rdata (pay_rd)
   );

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   // A tag below the clear boundary belongs to an entry from before a clear.
   assign live     = (tag_rd != '0) && (tag_rd >= bound_ff);
   assign hit      = live && (tag_rd == req_ff);
   assign ok       = live && (!hit_ff || (tag_rd > req_ff));
   // Round up to the next slot-zero number; a number already there moves a full ring.
   assign rounded  = (next_ff | 32'(DEPTH - 1)) + 32'd1;

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      next_in      = next_ff;
      wslot_in     = wslot_ff;
      bound_in     = bound_ff;
      req_in       = req_ff;
      op_in        = op_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      head_pop     = 1'b0;
      tag_we       = 1'b0;
      pay_we       = 1'b0;
      mem_re       = 1'b0;
      waddr        = wslot_ff;
      raddr        = head.slot;
      tag_wdata    = next_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            tag_we      = 1'b1;
            waddr       = init_cnt_ff;
            tag_wdata   = '0;
            init_cnt_in = init_cnt_ff + IDX_W'(1);
            if (init_cnt_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (head_valid) begin
               unique case (head.op) inside
                  OP_CREATE: begin
                     if (out_free) begin
                        head_pop     = 1'b1;
                        tag_we       = 1'b1;
                        pay_we       = 1'b1;
                        next_in      = next_ff + 32'd1;
                        wslot_in     = wslot_ff + IDX_W'(1);
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{res_found: 1'b1, res_id: next_ff,
                                         res_data: 32'(head.data)};
                     end
                  end
                  OP_CLEAR: begin
                     if (out_free) begin
                        head_pop     = 1'b1;
                        next_in      = rounded;
                        bound_in     = rounded;
                        wslot_in     = '0;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{res_found: 1'b0, res_id: rounded, res_data: '0};
                     end
                  end
                  OP_GET, OP_GET_NEXT: begin
                     head_pop = 1'b1;
                     mem_re   = 1'b1;
                     req_in   = head.id;
                     op_in    = head.op;
                     state_in = ST_LOOK1;
                  end
                  default: begin
                     state_in = ST_RUN;
                  end
               endcase
            end
         end
         ST_LOOK1: begin
            if (op_ff == OP_GET) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{res_found: hit, res_id: req_ff,
                                   res_data: hit ? 32'(pay_rd) : 32'd0};
                  state_in     = ST_RUN;
               end
            end else begin
               // Follow the reader's entry, or fall back to the oldest slot.
               mem_re   = 1'b1;
               raddr    = hit ? req_ff[IDX_W-1:0] + IDX_W'(1) : wslot_ff;
               hit_in   = hit;
               state_in = ST_LOOK2;
            end
         end
         ST_LOOK2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{res_found: ok, res_id: ok ? tag_rd : req_ff,
                                res_data: ok ? 32'(pay_rd) : 32'd0};
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         next_ff      <= 32'd1;
         wslot_ff     <= IDX_W'(1);
         bound_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         next_ff      <= next_in;
         wslot_ff     <= wslot_in;
         bound_ff     <= bound_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      op_ff  <= op_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;
   assign init_done       = (state_ff != ST_INIT);

endmodule
`default_nettype wire

>>> hdl/brst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Broadcast ring checker
// Port-level assertions on the broadcast ring, attached by bind.
// ----------------------------------------------------------------------------
module brst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_id,
   input logic [31:0] rsp_data
);

   // The tag sweep must start right after reset, so no request is taken then.
   a_sweep_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during the tag sweep");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_miss_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_data == 32'd0))
      else $error("response without an entry carries data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_id) && $stable(rsp_data)))
      else $error("stalled response beat changed");

endmodule

bind broadcast_ring_with_sequence_tags_unit brst_checker u_brst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_found (rsp_bus.payload.res_found),
   .rsp_id    (rsp_bus.payload.res_id),
   .rsp_data  (rsp_bus.payload.res_data)
);
`default_nettype wire

>>> tb/tb_broadcast_ring_with_sequence_tags_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Broadcast ring with sequence tags testbench
// Sends create, get, get-next and clear requests through the request channel
// and checks every response beat against a running prediction of the ring.
// Directed cases come first, then a full lap of the ring, an output stall
// that backs up the request side, and a long random mix of all four requests.
// ----------------------------------------------------------------------------
module tb_broadcast_ring_with_sequence_tags_unit;
   import brst_pkg::*;

   logic clock;
   logic reset;

   brst_req_if req_bus ();
   brst_rsp_if rsp_bus ();

   broadcast_ring_with_sequence_tags_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted ring contents.
   logic [31:0]      seq_next;
   logic [IDX_W-1:0] ring_wr_slot;
   logic [31:0]      clear_floor;
   logic [31:0]      ring_tag [DEPTH];
   logic [PAY_W-1:0] ring_data [DEPTH];

   rsp_payload_type pending_rsp [$];
   logic [31:0]     reader_last [4];

   int  fail_count = 0;
   int  found_count = 0;
   int  rsp_count = 0;
   int  op_count [4] = '{0, 0, 0, 0};
   int  rsp_hold_cycles = 0;
   bit  send_idle_on = 1'b1;
   bit  rsp_stall_on = 1'b1;
   bit  reset_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic bit slot_live(input logic [IDX_W-1:0] s);
      return ring_tag[s] != 32'd0 && ring_tag[s] >= clear_floor;
   endfunction

   // Applies one request to the predicted ring and returns its response.
   function automatic rsp_payload_type ring_predict(input req_payload_type beat);
      rsp_payload_type  r;
      logic [IDX_W-1:0] s;
      logic [IDX_W-1:0] n;
      bit               present;
      r.res_found = 1'b0;
      r.res_id    = beat.req_id;
      r.res_data  = '0;
      s = beat.req_id[IDX_W-1:0];
      present = slot_live(s) && ring_tag[s] == beat.req_id;
      case (op_type'(beat.operation))
         OP_CREATE: begin
            s = ring_wr_slot;
            ring_tag[s]  = seq_next;
            ring_data[s] = beat.in_data[PAY_W-1:0];
            r.res_found  = 1'b1;
            r.res_id     = seq_next;
            r.res_data   = 32'(beat.in_data[PAY_W-1:0]);
            seq_next     = seq_next + 32'd1;
            ring_wr_slot = s + IDX_W'(1);
         end
         OP_GET: begin
            if (present) begin
               r.res_found = 1'b1;
               r.res_data  = 32'(ring_data[s]);
            end
         end
         OP_GET_NEXT: begin
            // A reader whose number is gone restarts from the oldest slot.
            n = present ? s + IDX_W'(1) : ring_wr_slot;
            if (slot_live(n) && (!present || ring_tag[n] > beat.req_id)) begin
               r.res_found = 1'b1;
               r.res_id    = ring_tag[n];
               r.res_data  = 32'(ring_data[n]);
            end
         end
         default: begin
            seq_next     = seq_next + 32'(DEPTH) - 32'(seq_next[IDX_W-1:0]);
            clear_floor  = seq_next;
            ring_wr_slot = '0;
            r.res_id     = seq_next;
         end
      endcase
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_req(input op_type op, input logic [31:0] id,
                           input logic [31:0] data, output rsp_payload_type predicted);
      req_payload_type beat;
      int              gap;
      beat.operation = op;
      beat.req_id    = id;
      beat.in_data   = data;
      gap = send_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.payload <= beat;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predicted = ring_predict(beat);
      pending_rsp.push_back(predicted);
      op_count[op]++;
      if (predicted.res_found) found_count++;
      @(negedge clock);
   endtask

   initial begin
      rsp_payload_type want;
      int              stall;
      rsp_bus.ready = 1'b0;
      wait (reset_done);
      @(negedge clock);
      forever begin
         stall = rsp_stall_on ? $urandom_range(0, 16) : 0;
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request waiting for it");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.payload.res_found !== want.res_found) begin
               $error("res_found: expected %0b, got %0b", want.res_found,
                      rsp_bus.payload.res_found);
               fail_count++;
            end
            if (rsp_bus.payload.res_id !== want.res_id) begin
               $error("res_id: expected %h, got %h", want.res_id, rsp_bus.payload.res_id);
               fail_count++;
            end
            if (rsp_bus.payload.res_data !== want.res_data) begin
               $error("res_data: expected %h, got %h", want.res_data,
                      rsp_bus.payload.res_data);
               fail_count++;
            end
         end
         @(negedge clock);
      end
   end

   task automatic test_directed();
      rsp_payload_type r;
      send_req(OP_GET_NEXT, 32'd0, 32'd0, r);          // empty ring, dead oldest slot
      send_req(OP_GET, 32'd0, 32'hFFFF_FFFF, r);
      send_req(OP_GET, 32'hFFFF_FFFF, 32'd0, r);
      send_req(OP_CREATE, 32'hFFFF_FFFF, 32'd0, r);
      send_req(OP_CREATE, 32'd0, 32'hFFFF_FFFF, r);
      send_req(OP_CREATE, 32'd7, 32'hA5A5_5A5A, r);
      send_req(OP_GET, 32'd1, 32'd0, r);
      send_req(OP_GET, 32'd2, 32'd0, r);
      send_req(OP_GET, 32'd1025, 32'd0, r);           // same slot, other number
      send_req(OP_GET_NEXT, 32'd1, 32'd0, r);
      send_req(OP_GET_NEXT, 32'd2, 32'd0, r);
      send_req(OP_GET_NEXT, 32'd3, 32'd0, r);          // nothing newer
      send_req(OP_GET_NEXT, 32'hFFFF_FFFF, 32'd0, r);
      send_req(OP_CLEAR, 32'd0, 32'd0, r);
      send_req(OP_GET, 32'd2, 32'd0, r);               // tag now below the clear floor
      send_req(OP_GET_NEXT, 32'd2, 32'd0, r);
      send_req(OP_CREATE, 32'd0, 32'h5555_5555, r);
      send_req(OP_GET_NEXT, 32'd2, 32'd0, r);
      send_req(OP_GET_NEXT, r.res_id, 32'd0, r);
      send_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, r);
      send_req(OP_CLEAR, 32'd0, 32'd0, r);             // already on a slot-zero boundary
      send_req(OP_CREATE, 32'd0, 32'h8000_0001, r);
      send_req(OP_GET, r.res_id, 32'd0, r);
   endtask

   // Goes once around the ring so that old numbers are overwritten.
   task automatic test_ring_lap();
      rsp_payload_type r;
      logic [31:0]     oldest;
      send_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      repeat (DEPTH + 8) send_req(OP_CREATE, 32'd0, $urandom, r);
      oldest = seq_next - 32'(DEPTH) - 32'd3;
      send_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
      send_req(OP_GET_NEXT, oldest, 32'd0, r);         // overwritten, falls back
      send_req(OP_GET, oldest, 32'd0, r);
      send_req(OP_GET_NEXT, r.res_id, 32'd0, r);
      send_req(OP_GET_NEXT, ring_tag[DEPTH-1], 32'd0, r);  // last slot to slot zero
      send_req(OP_GET, ring_tag[0], 32'd0, r);
      send_req(OP_GET_NEXT, seq_next - 32'd1, 32'd0, r);
      send_req(OP_GET_NEXT, $urandom, 32'd0, r);
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_output_stall();
      rsp_payload_type r;
      logic [31:0]     last;
      send_idle_on = 1'b0;
      rsp_hold_cycles = 400;
      last = seq_next - 32'd1;
      repeat (8) begin
         send_req(OP_CREATE, 32'd0, $urandom, r);
         send_req(OP_GET_NEXT, last, 32'd0, r);
         last = r.res_id;
         send_req(OP_GET, last - 32'd1, 32'd0, r);
      end
      send_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int count);
      rsp_payload_type r;
      int              roll;
      int              k;
      logic [31:0]     id;
      logic [31:0]     data;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            send_idle_on = $urandom_range(0, 3) != 0;
            rsp_stall_on = $urandom_range(0, 3) != 0;
         end
         roll = $urandom_range(0, 99);
         k = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0:       data = 32'd0;
            1:       data = 32'hFFFF_FFFF;
            default: data = $urandom;
         endcase
         if (roll < 30) begin
            send_req(OP_CREATE, $urandom, data, r);
         end else if (roll < 50) begin
            case ($urandom_range(0, 9))
               0, 1:    id = $urandom;
               2, 3:    id = reader_last[k];
               default: id = seq_next - 32'd1 - 32'($urandom_range(0, 40));
            endcase
            send_req(OP_GET, id, data, r);
         end else if (roll < 98) begin
            // Readers mostly follow their own chain of numbers.
            id = ($urandom_range(0, 9) == 0) ? $urandom : reader_last[k];
            send_req(OP_GET_NEXT, id, data, r);
            reader_last[k] = r.res_id;
         end else begin
            send_req(OP_CLEAR, $urandom, data, r);
         end
      end
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      reset           = 1'b1;
      seq_next        = 32'd1;
      ring_wr_slot    = IDX_W'(1);
      clear_floor     = 32'd0;
      foreach (ring_tag[j]) begin
         ring_tag[j]  = '0;
         ring_data[j] = '0;
      end
      foreach (reader_last[j]) reader_last[j] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;
      @(negedge clock);

      test_directed();
      test_ring_lap();
      test_output_stall();
      test_random_traffic(850);

      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d creates, %0d gets, %0d get-next and %0d clears, including a full lap",
               op_count[OP_CREATE], op_count[OP_GET], op_count[OP_GET_NEXT],
               op_count[OP_CLEAR]);
      $display("of the ring and a long output stall; %0d responses, %0d with an entry.",
               rsp_count, found_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
